/* design/opsc_pkg.sv */
// opsc_pkg: shared types, constants and the fixed pattern table for the
// opcode pattern and sled scanner; no dependencies
`default_nettype none

package opsc_pkg;

  // width of the internal file position counter (outputs carry the low 32 bits)
  localparam int OFFSET_BITS   = 32;
  // number of table entries that take part in matching (1..TABLE_SIZE)
  localparam int PATTERN_COUNT = 17;

  localparam int TABLE_SIZE    = 17;
  localparam int HIST_BYTES    = 4;
  localparam int WINDOW_BITS   = 8 * (HIST_BYTES + 1);
  localparam int CFG_DATA_BITS = 17;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [2:0] FILL_MAX = 3'(HIST_BYTES);

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PATTERN_ENABLE  = 2'd0,
    CFG_SLED_BYTE       = 2'd1,
    CFG_MIN_SLED_LENGTH = 2'd2
  } cfg_index_t;

  localparam logic [TABLE_SIZE-1:0] PATTERN_ENABLE_RST  = 17'h1ffff;
  localparam logic [7:0]            SLED_BYTE_RST       = 8'h90;
  localparam logic [15:0]           MIN_SLED_LENGTH_RST = 16'd8;

  // pattern bytes in file order, newest byte in the low bits
  localparam logic [WINDOW_BITS-1:0] PAT_VALUE [TABLE_SIZE] = '{
    40'h00_0000_cd20, 40'h00_0000_cd21, 40'h00_0000_cd13, 40'h00_0000_cd10,
    40'h00_0000_cd16, 40'h00_0000_cd80, 40'h00_0000_0f05, 40'h00_0000_0f34,
    40'h00_0000_00cc, 40'h00_0000_ebfe, 40'h00_0055_8bec, 40'h00_5548_89e5,
    40'he8_0000_0000, 40'h00_0000_31c0, 40'h00_0000_0fa2, 40'h00_0000_0f31,
    40'h00_5045_0000
  };

  // pattern lengths in bytes
  localparam logic [2:0] PAT_LEN [TABLE_SIZE] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd2, 3'd2,
    3'd4
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0]           byte_offset;
    logic [TABLE_SIZE-1:0] hit_mask;
    logic                  sled_found;
    logic [31:0]           sled_start;
    logic [31:0]           sled_length;
    logic [15:0]           sled_total;
    logic                  stream_end;
  } out_t;

  // byte mask covering the newest len bytes of the window
  function automatic logic [WINDOW_BITS-1:0] pat_mask(input logic [2:0] len);
    logic [WINDOW_BITS-1:0] m;
    m = '0;
    for (int k = 0; k < HIST_BYTES + 1; k++) begin
      if (3'(k) < len) begin
        m[8*k +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* design/opcode_pattern_and_sled_scanner_core.sv */
// opcode_pattern_and_sled_scanner_core: top level of the byte signature scanner
// depends on opsc_pkg and opsc_matcher
`default_nettype none

// Scans a file presented one byte per transfer on in_data, with last_byte set
// on the final byte. Every accepted byte produces exactly one result transfer
// on out_data, in order: the byte's offset, a mask of the enabled table
// patterns (1 to 5 bytes) that end on it, and a sled report when a run of
// sled_byte of at least min_sled_length bytes closes on it (the first
// different byte closes a run, and so does the final byte of the file).
// Throughput is one byte per clock while out_stall stays low, and each
// result is registered on its way out. The pattern compare and the history/run/
// position update are a single register-to-register step, which is what sets
// the one-byte-per-clock figure. A two-entry output (result register plus
// skid register) lets a byte be taken in the same cycle the previous result
// is still held by out_stall; in_stall rises only once the skid is full.
// After the final byte all scan state (history, offset, run, sled count)
// returns to zero; configuration registers keep their values and are to be
// written only while no transfer is pending.

module opcode_pattern_and_sled_scanner_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_write,
  input  wire logic [opsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [opsc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // byte input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire opsc_pkg::in_t                       in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output opsc_pkg::out_t                           out_data
);

  // configuration registers
  logic [opsc_pkg::TABLE_SIZE-1:0] pattern_enable;
  logic [7:0]                      sled_byte;
  logic [15:0]                     min_sled_length;

  // scan state
  logic [8*opsc_pkg::HIST_BYTES-1:0] byte_history;
  logic [2:0]                        history_fill;
  logic [opsc_pkg::OFFSET_BITS-1:0]  position_counter;
  logic [31:0]                       run_length;
  logic [31:0]                       run_begin;
  logic [15:0]                       sled_counter;

  // output staging
  logic           skid_valid;
  opsc_pkg::out_t skid_data;

  // per-byte combinational results
  logic                                in_xfer;
  logic                                out_xfer;
  logic [opsc_pkg::OFFSET_BITS+31:0]   pos_wide;
  logic [31:0]                         pos32;
  logic                                is_sled;
  logic [31:0]                         run_length_next;
  logic [31:0]                         run_begin_next;
  logic                                run_closes;
  logic [15:0]                         min_len;
  logic                                found;
  logic [15:0]                         sled_counter_next;
  logic [opsc_pkg::TABLE_SIZE-1:0]     hits;
  opsc_pkg::out_t                      result;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // pattern compare over {history, current byte}
  opsc_matcher u_matcher (
    .window   ({byte_history, in_data.data_byte}),
    .fill     (history_fill),
    .enable   (pattern_enable),
    .hit_mask (hits)
  );

  // offset reported as its low 32 bits, zero-extended when narrower
  assign pos_wide = {32'd0, position_counter};
  assign pos32    = pos_wide[31:0];

  // sled run tracking
  assign is_sled = (in_data.data_byte == sled_byte);
  assign min_len = (min_sled_length == 16'd0) ? 16'd1 : min_sled_length;

  always_comb begin
    run_length_next = run_length;
    run_begin_next  = run_begin;
    if (is_sled) begin
      if (run_length == 32'd0) begin
        run_begin_next = pos32;
      end
      if (run_length != 32'hffff_ffff) begin
        run_length_next = run_length + 32'd1;
      end
    end
  end

  // a run closes on the first other byte, or at the end of the file
  assign run_closes = (run_length_next != 32'd0) && (!is_sled || in_data.last_byte);
  assign found      = run_closes && (run_length_next >= {16'd0, min_len});
  assign sled_counter_next = (found && sled_counter != 16'hffff) ?
                             sled_counter + 16'd1 : sled_counter;

  always_comb begin
    result.byte_offset = pos32;
    result.hit_mask    = hits;
    result.sled_found  = found;
    result.sled_start  = found ? run_begin_next : 32'd0;
    result.sled_length = found ? run_length_next : 32'd0;
    result.sled_total  = sled_counter_next;
    result.stream_end  = in_data.last_byte;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_enable  <= opsc_pkg::PATTERN_ENABLE_RST;
      sled_byte       <= opsc_pkg::SLED_BYTE_RST;
      min_sled_length <= opsc_pkg::MIN_SLED_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        opsc_pkg::CFG_PATTERN_ENABLE:  pattern_enable  <= cfg_data;
        opsc_pkg::CFG_SLED_BYTE:       sled_byte       <= cfg_data[7:0];
        opsc_pkg::CFG_MIN_SLED_LENGTH: min_sled_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // scan state update, one byte per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_history     <= '0;
      history_fill     <= '0;
      position_counter <= '0;
      run_length       <= '0;
      run_begin        <= '0;
      sled_counter     <= '0;
    end else if (in_xfer) begin
      if (in_data.last_byte) begin
        // end of file: everything starts over
        byte_history     <= '0;
        history_fill     <= '0;
        position_counter <= '0;
        run_length       <= '0;
        run_begin        <= '0;
        sled_counter     <= '0;
      end else begin
        byte_history <= {byte_history[8*opsc_pkg::HIST_BYTES-9:0], in_data.data_byte};
        if (history_fill < opsc_pkg::FILL_MAX) begin
          history_fill <= history_fill + 3'd1;
        end
        if (position_counter != '1) begin
          position_counter <= position_counter + opsc_pkg::OFFSET_BITS'(1);
        end
        run_length   <= run_closes ? 32'd0 : run_length_next;
        run_begin    <= run_closes ? 32'd0 : run_begin_next;
        sled_counter <= sled_counter_next;
      end
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_xfer) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_xfer;
        end
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_xfer) begin
        out_data <= result;
      end
    end else if (in_xfer) begin
      skid_data <= result;
    end
  end

  // the skid register only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output is empty");

  // a reported sled always has a length of at least one
  a_found_has_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sled_found) |-> (out_data.sled_length != 32'd0))
    else $error("sled reported with zero length");

  // the final byte of a file leaves all scan state cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.last_byte) |=>
      (history_fill == 3'd0 && position_counter == '0 &&
       run_length == 32'd0 && sled_counter == 16'd0))
    else $error("scan state not cleared after final byte");

  // a run in progress never has a start beyond the current position
  a_run_begin_bounded: assert property (@(posedge clk) disable iff (rst)
    (run_length != 32'd0) |-> (run_begin <= pos32))
    else $error("sled run start lies past the current offset");

endmodule

`default_nettype wire

/* design/opsc_matcher.sv */
// opsc_matcher: compares the five-byte window against the fixed pattern table
// depends on opsc_pkg
`default_nettype none

module opsc_matcher (
  input  wire logic [opsc_pkg::WINDOW_BITS-1:0] window,
  input  wire logic [2:0]                       fill,
  input  wire logic [opsc_pkg::TABLE_SIZE-1:0]  enable,
  output logic      [opsc_pkg::TABLE_SIZE-1:0]  hit_mask
);

  logic [3:0]                      seen;
  logic [opsc_pkg::TABLE_SIZE-1:0] raw_hit;

  // bytes available: the history plus the current one
  assign seen = {1'b0, fill} + 4'd1;

  always_comb begin
    raw_hit = '0;
    for (int i = 0; i < opsc_pkg::TABLE_SIZE; i++) begin
      if (i < opsc_pkg::PATTERN_COUNT) begin
        raw_hit[i] = (seen >= {1'b0, opsc_pkg::PAT_LEN[i]}) &&
                     ((window & opsc_pkg::pat_mask(opsc_pkg::PAT_LEN[i]))
                       == opsc_pkg::PAT_VALUE[i]);
      end
    end
  end

  assign hit_mask = raw_hit & enable;

endmodule

`default_nettype wire

/* sim/opcode_pattern_and_sled_scanner_core_tb.sv */
// opcode_pattern_and_sled_scanner_core_tb: self-checking bench for the byte signature scanner
// drives files of bytes, predicts every result transfer and compares field by field
// depends on opsc_pkg and opcode_pattern_and_sled_scanner_core
`timescale 1ns / 100ps

module opcode_pattern_and_sled_scanner_core_tb;

  localparam int IDLE_PCT   = 9;
  localparam int HOLD_LEN   = 60;    // long receiver hold-off, in cycles
  localparam int HOLD_AT    = 150;   // input transfers before the hold-off starts
  localparam int STUCK_MAX  = 1000;  // cycles with no transfer before giving up

  // signature table, newest byte in the low bits
  localparam logic [39:0] SIG_VAL [17] = '{
    40'h00_0000_cd20, 40'h00_0000_cd21, 40'h00_0000_cd13, 40'h00_0000_cd10,
    40'h00_0000_cd16, 40'h00_0000_cd80, 40'h00_0000_0f05, 40'h00_0000_0f34,
    40'h00_0000_00cc, 40'h00_0000_ebfe, 40'h00_0055_8bec, 40'h00_5548_89e5,
    40'he8_0000_0000, 40'h00_0000_31c0, 40'h00_0000_0fa2, 40'h00_0000_0f31,
    40'h00_5045_0000
  };
  localparam int SIG_LEN [17] = '{2, 2, 2, 2, 2, 2, 2, 2, 1, 2, 3, 4, 5, 2, 2, 2, 4};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  opsc_pkg::cfg_index_t cfg_index = opsc_pkg::CFG_PATTERN_ENABLE;
  logic [opsc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  opsc_pkg::in_t        in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  opsc_pkg::out_t       out_data;

  opcode_pattern_and_sled_scanner_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies as the scanner should hold them
  logic [16:0] en_mask  = 17'h1ffff;
  logic [7:0]  sled_val = 8'h90;
  logic [15:0] min_run  = 16'd8;

  // scan state of the predictor
  logic [31:0]                      hist      = '0;
  int unsigned                      hist_fill = 0;
  logic [opsc_pkg::OFFSET_BITS-1:0] pos       = '0;
  logic [31:0]                      run_len   = '0;
  logic [31:0]                      run_start = '0;
  logic [15:0]                      sled_cnt  = '0;

  opsc_pkg::in_t  byte_queue [$];   // bytes waiting to be offered
  opsc_pkg::out_t scan_expect [$];  // predicted results, oldest first
  opsc_pkg::out_t want_res;

  bit   calm = 1'b0;      // no idling on either side while set
  bit   hold_armed = 1'b1;
  int   hold_left = 0;
  int   in_count = 0;
  int   stuck_cycles = 0;
  int   fail_count = 0;
  int   bytes_planned = 0;
  int   files_planned = 0;
  int   sled_reports = 0;
  int   result_count = 0;
  logic [16:0] hit_union = '0;

  // one scanner step: pattern hits at this byte, sled run tracking, then state update
  function automatic opsc_pkg::out_t scan_step(input opsc_pkg::in_t it);
    opsc_pkg::out_t r;
    logic [39:0]    win;
    logic [39:0]    m;
    logic [31:0]    need;
    r = '0;
    win = {hist, it.data_byte};
    for (int i = 0; i < 17; i++) begin
      m = ~(40'hff_ffff_ffff << (8 * SIG_LEN[i]));
      // invalid history bytes never take part in a match
      if (i < opsc_pkg::PATTERN_COUNT && hist_fill + 1 >= SIG_LEN[i] &&
          (win & m) == SIG_VAL[i]) begin
        r.hit_mask[i] = 1'b1;
      end
    end
    r.hit_mask &= en_mask;
    need = (min_run == 16'd0) ? 32'd1 : {16'd0, min_run};
    if (it.data_byte == sled_val) begin
      if (run_len == 32'd0) run_start = pos[31:0];
      if (run_len != '1) run_len++;
    end
    // run closes on the first other byte, or on the final byte of the file
    if (run_len != 32'd0 && (it.data_byte != sled_val || it.last_byte)) begin
      if (run_len >= need) begin
        r.sled_found  = 1'b1;
        r.sled_start  = run_start;
        r.sled_length = run_len;
        if (sled_cnt != '1) sled_cnt++;
      end
      run_len = '0;
      run_start = '0;
    end
    r.byte_offset = pos[31:0];
    r.sled_total  = sled_cnt;
    r.stream_end  = it.last_byte;
    if (it.last_byte) begin
      hist = '0;
      hist_fill = 0;
      pos = '0;
      run_len = '0;
      run_start = '0;
      sled_cnt = '0;
    end else begin
      hist = win[31:0];
      if (hist_fill < 4) hist_fill++;
      if (pos != '1) pos++;
    end
    return r;
  endfunction

  // sender: holds a stalled byte, otherwise offers the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_expect.push_back(scan_step(in_data));
        in_count <= in_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the skid fills and in_stall rises
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && in_count >= HOLD_AT) begin
      hold_armed <= 1'b0;
      hold_left  <= HOLD_LEN - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic check_field(input string fname, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, e, a);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (scan_expect.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want_res = scan_expect.pop_front();
        check_field("byte_offset", want_res.byte_offset, out_data.byte_offset);
        check_field("hit_mask",    32'(want_res.hit_mask), 32'(out_data.hit_mask));
        check_field("sled_found",  32'(want_res.sled_found), 32'(out_data.sled_found));
        check_field("sled_start",  want_res.sled_start, out_data.sled_start);
        check_field("sled_length", want_res.sled_length, out_data.sled_length);
        check_field("sled_total",  32'(want_res.sled_total), 32'(out_data.sled_total));
        check_field("stream_end",  32'(want_res.stream_end), 32'(out_data.stream_end));
        result_count++;
        hit_union |= out_data.hit_mask;
        if (out_data.sled_found === 1'b1) sled_reports++;
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("opcode_pattern_and_sled_scanner_core_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic void queue_byte(input logic [7:0] b);
    byte_queue.push_back(opsc_pkg::in_t'{data_byte: b, last_byte: 1'b0});
    bytes_planned++;
  endfunction

  // flag the newest queued byte as the end of its file
  function automatic void close_file();
    opsc_pkg::in_t it;
    it = byte_queue.pop_back();
    it.last_byte = 1'b1;
    byte_queue.push_back(it);
    files_planned++;
  endfunction

  // one file mixing whole and cut-off signatures, sled runs (near the minimum when it is at most 20) and noise
  task automatic add_file(input int target);
    int          n;
    int          r;
    int          k;
    int          len;
    int          need;
    logic [7:0]  b;
    n = 0;
    while (n < target) begin
      r = $urandom_range(99);
      if (r < 40) begin
        k = $urandom_range(16);
        len = SIG_LEN[k];
        if (r >= 30) len = $urandom_range(1, len);  // broken signature
        for (int j = SIG_LEN[k] - 1; j >= SIG_LEN[k] - len; j--) queue_byte(SIG_VAL[k][8*j +: 8]);
        n += len;
      end else if (r < 60) begin
        need = (min_run == 16'd0) ? 1 : int'(min_run);
        if (need > 20) len = $urandom_range(1, 20);
        else len = $urandom_range((need > 2) ? need - 2 : 1, need + 3);
        repeat (len) queue_byte(sled_val);
        n += len;
      end else if (r < 75) begin
        k = $urandom_range(16);
        b = SIG_VAL[k][8*$urandom_range(SIG_LEN[k] - 1) +: 8];
        queue_byte(($urandom_range(3) == 0) ? sled_val : b);
        n++;
      end else begin
        queue_byte(8'($urandom_range(255)));
        n++;
      end
    end
    close_file();
  endtask

  task automatic add_random(input int count);
    int start;
    start = bytes_planned;
    while (bytes_planned - start < count) begin
      // mostly short files, now and then a longer one
      add_file(($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40));
    end
  endtask

  // wait until every queued byte is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || scan_expect.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input opsc_pkg::cfg_index_t idx,
                           input logic [opsc_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      opsc_pkg::CFG_PATTERN_ENABLE:  en_mask  = data[16:0];
      opsc_pkg::CFG_SLED_BYTE:       sled_val = data[7:0];
      opsc_pkg::CFG_MIN_SLED_LENGTH: min_run  = data[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  initial begin
    // directed: one-byte file, no match across a file boundary, five-byte call
    // signature as soon as the history fills, runs closed by another byte and by last
    queue_byte(8'hcc); close_file();
    queue_byte(8'hcd); close_file();
    queue_byte(8'h20); close_file();
    queue_byte(8'he8); repeat (4) queue_byte(8'h00); close_file();
    repeat (8) queue_byte(8'h90);
    queue_byte(8'h41);
    repeat (8) queue_byte(8'h90);
    close_file();
    add_random(190);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    drain();

    // all patterns off, zero as the sled byte, zero minimum acting as one
    write_reg(opsc_pkg::CFG_PATTERN_ENABLE, 17'h00000);
    write_reg(opsc_pkg::CFG_SLED_BYTE, 17'h15a00);
    write_reg(opsc_pkg::CFG_MIN_SLED_LENGTH, 17'h00000);
    add_random(180);
    drain();

    // random enables, top sled byte, largest minimum
    write_reg(opsc_pkg::CFG_PATTERN_ENABLE, 17'($urandom_range(17'h1ffff)));
    write_reg(opsc_pkg::CFG_SLED_BYTE, 17'h000ff);
    write_reg(opsc_pkg::CFG_MIN_SLED_LENGTH, 17'h0ffff);
    add_random(180);
    drain();

    // sled byte that is also a signature, short minimum, no idling on either side
    write_reg(opsc_pkg::CFG_PATTERN_ENABLE, 17'h1ffff);
    write_reg(opsc_pkg::CFG_SLED_BYTE, 17'h000cc);
    write_reg(opsc_pkg::CFG_MIN_SLED_LENGTH, 17'h10002);
    calm = 1'b1;
    add_random(190);
    drain();
    calm = 1'b0;

    write_reg(opsc_pkg::CFG_PATTERN_ENABLE, 17'($urandom_range(17'h1ffff)));
    write_reg(opsc_pkg::CFG_SLED_BYTE, 17'($urandom_range(255)));
    write_reg(opsc_pkg::CFG_MIN_SLED_LENGTH, 17'($urandom_range(1, 12)));
    add_random(180);
    drain();
    repeat (5) @(posedge clk);

    $display("scanned %0d bytes in %0d files, %0d results checked, %0d sled reports",
             bytes_planned, files_planned, result_count, sled_reports);
    $display("signature hits seen on mask %05h, five register settings", hit_union);
    if (fail_count == 0) begin
      $display("opcode_pattern_and_sled_scanner_core_tb passed");
    end else begin
      $display("opcode_pattern_and_sled_scanner_core_tb failed");
    end
    $finish;
  end

endmodule
